/* hdl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths, reset values, register codes and control structures for the
// random permutation by rank core.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int MAX_COUNT_DEF = 64;

    localparam int M_W     = 33;
    localparam int A_W     = 24;
    localparam int C_W     = 32;
    localparam int N_W     = 7;
    localparam int Z_W     = 35;
    localparam int V_W     = 33;
    localparam int OUT_W   = 6;
    localparam int T_W     = 60;
    localparam int PL_W    = 18;
    localparam int PROD_W  = A_W + PL_W;
    localparam int B_W     = $clog2(T_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;

    localparam logic [M_W-1:0] MODULUS_RST    = 33'd2147483647;
    localparam logic [A_W-1:0] MULTIPLIER_RST = 24'd48271;
    localparam logic [C_W-1:0] INCREMENT_RST  = 32'd0;
    localparam logic [N_W-1:0] COUNT_RST      = 7'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS    = 2'd0,
        REG_MULTIPLIER = 2'd1,
        REG_INCREMENT  = 2'd2,
        REG_COUNT      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic load_seed;
        logic mul_lo;
        logic mul_hi;
        logic add;
        logic rem_clr;
        logic mod_step;
        logic store;
        logic latch_vi;
        logic rank_clr;
        logic cmp;
        logic tie_ok;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_zero;
    } t_dp_sts;

endpackage

/* hdl/lpr_ctrl.sv */
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: runs the generator steps, the bitwise reduction, the rank count
// for every position and the output handshake.
// ----------------------------------------------------------------------------
module lpr_ctrl #(
    parameter int MAX_COUNT = lpr_pkg::MAX_COUNT_DEF,
    parameter int IW        = $clog2(MAX_COUNT)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lpr_pkg::N_W-1:0]   i_count,
    input  logic                      i_seed_valid,
    output logic                      o_seed_ready,
    output logic                      o_rank_valid,
    input  logic                      i_rank_ready,
    output logic [lpr_pkg::OUT_W-1:0] o_position,
    output logic                      o_last,
    output lpr_pkg::t_dp_cmd          o_cmd,
    input  lpr_pkg::t_dp_sts          i_sts,
    output logic [IW-1:0]             o_wr_addr,
    output logic [IW-1:0]             o_rd_addr
);

    localparam int CW = (IW + 1 > lpr_pkg::N_W) ? IW + 1 : lpr_pkg::N_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_MOD,
        S_STORE,
        S_RANK_LD,
        S_RANK_VI,
        S_RANK,
        S_RANK_TAIL,
        S_EMIT
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_n, n_n;
    logic [CW-1:0]            r_i, n_i;
    logic [CW-1:0]            r_j, n_j;
    logic [lpr_pkg::B_W-1:0]  r_b, n_b;
    logic                     r_cmp_v, n_cmp_v;
    logic                     r_jlt, n_jlt;
    logic                     r_out_valid, n_out_valid;
    logic                     r_last, n_last;
    logic [CW-1:0]            cnt_ext;
    logic [CW-1:0]            cnt_sat;

    assign cnt_ext = CW'(i_count);
    assign cnt_sat = (cnt_ext > CW'(MAX_COUNT)) ? CW'(MAX_COUNT) : cnt_ext;

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_b         = r_b;
        n_cmp_v     = 1'b0;
        n_jlt       = r_jlt;
        n_out_valid = r_out_valid;
        n_last      = r_last;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_seed_valid) begin
                    n_n = cnt_sat;
                    n_i = '0;
                    if (cnt_sat != '0) begin
                        n_state = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO: begin
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_b     = '0;
                n_state = i_sts.mod_zero ? S_STORE : S_MOD;
            end
            S_MOD: begin
                n_b = r_b + 1'b1;
                if (r_b == lpr_pkg::B_W'(lpr_pkg::T_W - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (r_i == r_n - 1'b1) begin
                    n_i     = '0;
                    n_state = S_RANK_LD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_MUL_LO;
                end
            end
            S_RANK_LD: begin
                n_j     = '0;
                n_state = S_RANK_VI;
            end
            S_RANK_VI, S_RANK: begin
                n_j     = r_j + 1'b1;
                n_cmp_v = 1'b1;
                n_jlt   = (r_j < r_i);
                n_state = (r_j == r_n - 1'b1) ? S_RANK_TAIL : S_RANK;
            end
            S_RANK_TAIL: begin
                n_last      = (r_i == r_n - 1'b1);
                n_out_valid = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_rank_ready) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_RANK_LD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_b         <= '0;
            r_cmp_v     <= 1'b0;
            r_jlt       <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_i         <= n_i;
            r_j         <= n_j;
            r_b         <= n_b;
            r_cmp_v     <= n_cmp_v;
            r_jlt       <= n_jlt;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_seed = (r_state == S_IDLE) && i_seed_valid;
        o_cmd.mul_lo    = (r_state == S_MUL_LO);
        o_cmd.mul_hi    = (r_state == S_MUL_HI);
        o_cmd.add       = (r_state == S_ADD);
        o_cmd.rem_clr   = (r_state == S_ADD);
        o_cmd.mod_step  = (r_state == S_MOD);
        o_cmd.store     = (r_state == S_STORE);
        o_cmd.latch_vi  = (r_state == S_RANK_VI);
        o_cmd.rank_clr  = (r_state == S_RANK_VI);
        o_cmd.cmp       = r_cmp_v;
        o_cmd.tie_ok    = r_jlt;
    end

    assign o_seed_ready = (r_state == S_IDLE);
    assign o_rank_valid = r_out_valid;
    assign o_position   = r_i[lpr_pkg::OUT_W-1:0];
    assign o_last       = r_last;
    assign o_wr_addr    = r_i[IW-1:0];
    assign o_rd_addr    = (r_state == S_RANK_LD) ? r_i[IW-1:0] : r_j[IW-1:0];

    a_ready_excludes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seed_ready |-> !o_rank_valid)
        else $error("input ready while a word is pending");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_i < r_n))
        else $error("position index beyond permutation length");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_rank_ready && r_last) |=> (r_state == S_IDLE))
        else $error("final word did not end the permutation");

    a_cmp_in_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_v |-> ((r_state == S_RANK) || (r_state == S_RANK_TAIL)))
        else $error("compare outside the rank pass");

endmodule

/* hdl/lpr_dp.sv */
// ----------------------------------------------------------------------------
// lpr_dp
// Datapath: split multiply, bitwise restoring reduction, value memory and
// rank accumulator.
// ----------------------------------------------------------------------------
module lpr_dp #(
    parameter int MAX_COUNT = lpr_pkg::MAX_COUNT_DEF,
    parameter int IW        = $clog2(MAX_COUNT)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lpr_pkg::M_W-1:0]   i_modulus,
    input  logic [lpr_pkg::A_W-1:0]   i_multiplier,
    input  logic [lpr_pkg::C_W-1:0]   i_increment,
    input  logic [lpr_pkg::Z_W-1:0]   i_seed,
    input  lpr_pkg::t_dp_cmd          i_cmd,
    output lpr_pkg::t_dp_sts          o_sts,
    input  logic [IW-1:0]             i_wr_addr,
    input  logic [IW-1:0]             i_rd_addr,
    output logic [lpr_pkg::OUT_W-1:0] o_rank
);

    localparam int CW = (IW + 1 > lpr_pkg::N_W) ? IW + 1 : lpr_pkg::N_W;

    logic [lpr_pkg::V_W-1:0]    r_mem [MAX_COUNT];
    logic [lpr_pkg::V_W-1:0]    r_rd_data;
    logic [lpr_pkg::Z_W-1:0]    r_z;
    logic [lpr_pkg::PROD_W-1:0] r_prod;
    logic [lpr_pkg::T_W-1:0]    r_t;
    logic [lpr_pkg::V_W-1:0]    r_rem;
    logic [lpr_pkg::V_W-1:0]    r_vi;
    logic [CW-1:0]              r_rank;

    logic [lpr_pkg::PL_W-1:0]   prod_op;
    logic [lpr_pkg::PROD_W-1:0] prod;
    logic [lpr_pkg::V_W:0]      sh;
    logic [lpr_pkg::V_W:0]      m_ext;
    logic                       ge;
    logic [lpr_pkg::V_W-1:0]    n_rem;
    logic [lpr_pkg::V_W-1:0]    res;
    logic                       hit;

    assign prod_op = i_cmd.mul_hi ? lpr_pkg::PL_W'(r_z[lpr_pkg::Z_W-1:lpr_pkg::PL_W])
                                  : r_z[lpr_pkg::PL_W-1:0];
    assign prod    = i_multiplier * prod_op;

    assign sh    = {r_rem, r_t[lpr_pkg::T_W-1]};
    assign m_ext = {1'b0, i_modulus};
    assign ge    = (sh >= m_ext);
    assign n_rem = ge ? lpr_pkg::V_W'(sh - m_ext) : sh[lpr_pkg::V_W-1:0];

    assign o_sts.mod_zero = (i_modulus == '0);
    assign res = o_sts.mod_zero ? r_t[lpr_pkg::V_W-1:0] : r_rem;

    assign hit = (r_rd_data < r_vi) || ((r_rd_data == r_vi) && i_cmd.tie_ok);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_z <= i_seed;
        end else if (i_cmd.store) begin
            r_z <= lpr_pkg::Z_W'(res);
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_hi) begin
            r_t <= lpr_pkg::T_W'(r_prod) + lpr_pkg::T_W'(i_increment);
        end else if (i_cmd.add) begin
            r_t <= r_t + (lpr_pkg::T_W'(r_prod) << lpr_pkg::PL_W);
        end else if (i_cmd.mod_step) begin
            r_t <= {r_t[lpr_pkg::T_W-2:0], 1'b0};
        end
        if (i_cmd.rem_clr) begin
            r_rem <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem <= n_rem;
        end
        if (i_cmd.store) begin
            r_mem[i_wr_addr] <= res;
        end
        r_rd_data <= r_mem[i_rd_addr];
        if (i_cmd.latch_vi) begin
            r_vi <= r_rd_data;
        end
        if (i_cmd.rank_clr) begin
            r_rank <= '0;
        end else if (i_cmd.cmp && hit) begin
            r_rank <= r_rank + 1'b1;
        end
    end

    assign o_rank = r_rank[lpr_pkg::OUT_W-1:0];

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.mod_step) && !o_sts.mod_zero) |-> (r_rem < i_modulus))
        else $error("partial remainder not below the modulus");

endmodule

/* hdl/lcg_permutation_by_rank_core.sv */
// ----------------------------------------------------------------------------
// lcg_permutation_by_rank_core
// Random permutation by rank from a linear congruential generator.
//
//   channel  direction  handshake                       payload
//   seed     in         i_seed_valid / o_seed_ready     i_seed
//   rank     out        o_rank_valid / i_rank_ready     o_rank, o_position, o_last
//   config   in         i_cfg_we                        i_cfg_idx, i_cfg_data
//
// Each generator step runs the split multiply as low-half, high-half and add
// steps, then, unless the modulus is zero, the one-bit restoring reduction over
// the 60-bit sum; ranking reads the value memory once per cycle.
// Reset is synchronous and active low; no clearing pass is needed.
// A seed is taken only when no word of the previous permutation is pending.
// ----------------------------------------------------------------------------
module lcg_permutation_by_rank_core #(
    parameter int MAX_COUNT = lpr_pkg::MAX_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_seed_valid,
    output logic                           o_seed_ready,
    input  logic [lpr_pkg::Z_W-1:0]        i_seed,
    output logic                           o_rank_valid,
    input  logic                           i_rank_ready,
    output logic [lpr_pkg::OUT_W-1:0]      o_rank,
    output logic [lpr_pkg::OUT_W-1:0]      o_position,
    output logic                           o_last
);

    localparam int IW = $clog2(MAX_COUNT);

    logic [lpr_pkg::M_W-1:0] r_modulus;
    logic [lpr_pkg::A_W-1:0] r_multiplier;
    logic [lpr_pkg::C_W-1:0] r_increment;
    logic [lpr_pkg::N_W-1:0] r_count;

    lpr_pkg::t_dp_cmd cmd;
    lpr_pkg::t_dp_sts sts;
    logic [IW-1:0]    wr_addr;
    logic [IW-1:0]    rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= lpr_pkg::MODULUS_RST;
            r_multiplier <= lpr_pkg::MULTIPLIER_RST;
            r_increment  <= lpr_pkg::INCREMENT_RST;
            r_count      <= lpr_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpr_pkg::REG_MODULUS:    r_modulus    <= i_cfg_data[lpr_pkg::M_W-1:0];
                lpr_pkg::REG_MULTIPLIER: r_multiplier <= i_cfg_data[lpr_pkg::A_W-1:0];
                lpr_pkg::REG_INCREMENT:  r_increment  <= i_cfg_data[lpr_pkg::C_W-1:0];
                lpr_pkg::REG_COUNT:      r_count      <= i_cfg_data[lpr_pkg::N_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lpr_ctrl #(
        .MAX_COUNT (MAX_COUNT),
        .IW        (IW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_count      (r_count),
        .i_seed_valid (i_seed_valid),
        .o_seed_ready (o_seed_ready),
        .o_rank_valid (o_rank_valid),
        .i_rank_ready (i_rank_ready),
        .o_position   (o_position),
        .o_last       (o_last),
        .o_cmd        (cmd),
        .i_sts        (sts),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr)
    );

    lpr_dp #(
        .MAX_COUNT (MAX_COUNT),
        .IW        (IW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_modulus    (r_modulus),
        .i_multiplier (r_multiplier),
        .i_increment  (r_increment),
        .i_seed       (i_seed),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_wr_addr    (wr_addr),
        .i_rd_addr    (rd_addr),
        .o_rank       (o_rank)
    );

endmodule

/* bench/lcg_permutation_by_rank_core_test.sv */
// ----------------------------------------------------------------------------
// lcg_permutation_by_rank_core_test
// Self-checking bench for the random permutation by rank core. A short table
// of directed rows covers reset values, modulus extremes, ties, zero and
// saturated counts and wide seeds. Random phases follow under changing
// register settings and handshake idling. Each rank word is checked against
// an in-bench generator and rank predictor, or against the identity order for rows with a known order.
// ----------------------------------------------------------------------------
module lcg_permutation_by_rank_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N       = lpr_pkg::MAX_COUNT_DEF;
    localparam int LIMIT       = 10_000_000;
    localparam int HOLD_CYCLES = 2500;
    localparam int PHASES      = 10;

    typedef enum logic {ROW_CFG, ROW_SEED} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        lpr_pkg::t_reg_idx              idx;
        logic [lpr_pkg::CFG_DATA_W-1:0] data;
        logic [lpr_pkg::Z_W-1:0]        seed;
        int                             in_order;
    } t_plan_row;

    typedef struct packed {
        logic [lpr_pkg::OUT_W-1:0] rank;
        logic [lpr_pkg::OUT_W-1:0] position;
        logic                      last;
    } t_rank_word;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lpr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lpr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_seed_valid;
    logic                           o_seed_ready;
    logic [lpr_pkg::Z_W-1:0]        i_seed;
    logic                           o_rank_valid;
    logic                           i_rank_ready;
    logic [lpr_pkg::OUT_W-1:0]      o_rank;
    logic [lpr_pkg::OUT_W-1:0]      o_position;
    logic                           o_last;

    logic [lpr_pkg::M_W-1:0] cfg_modulus;
    logic [lpr_pkg::A_W-1:0] cfg_multiplier;
    logic [lpr_pkg::C_W-1:0] cfg_increment;
    logic [lpr_pkg::N_W-1:0] cfg_count;

    t_rank_word expected_ranks[$];
    t_plan_row  plan[$];
    int         mismatches;
    int         snd_idle;
    int         rcv_idle;
    int         cycle_cnt;
    int         hold_left;
    logic       hold_req;
    logic       seeds_in_flight;

    lcg_permutation_by_rank_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_seed_valid (i_seed_valid),
        .o_seed_ready (o_seed_ready),
        .i_seed       (i_seed),
        .o_rank_valid (o_rank_valid),
        .i_rank_ready (i_rank_ready),
        .o_rank       (o_rank),
        .o_position   (o_position),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int active_count();
        return (int'(cfg_count) > MAX_N) ? MAX_N : int'(cfg_count);
    endfunction

    function automatic int drain_cycles();
        int n;
        n = active_count();
        return 64 * n + n * (n + 3) + 64;
    endfunction

    task automatic predict_ranks(input logic [lpr_pkg::Z_W-1:0] seed);
        logic [63:0]             z;
        logic [63:0]             t;
        logic [lpr_pkg::V_W-1:0] vals [MAX_N];
        t_rank_word              w;
        int                      n;
        int                      r;
        n = active_count();
        z = 64'(seed);
        for (int i = 0; i < n; i++) begin
            t = 64'(cfg_multiplier) * z + 64'(cfg_increment);
            z = (cfg_modulus == '0) ? (t & 64'h1_FFFF_FFFF) : (t % 64'(cfg_modulus));
            vals[i] = z[lpr_pkg::V_W-1:0];
        end
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int j = 0; j < n; j++) begin
                if (vals[j] < vals[i] || (vals[j] == vals[i] && j < i)) begin
                    r++;
                end
            end
            w.rank     = lpr_pkg::OUT_W'(r);
            w.position = lpr_pkg::OUT_W'(i);
            w.last     = (i + 1 == n);
            expected_ranks.push_back(w);
        end
    endtask

    task automatic expect_in_order(input int n);
        t_rank_word w;
        for (int i = 0; i < n; i++) begin
            w.rank     = lpr_pkg::OUT_W'(i);
            w.position = lpr_pkg::OUT_W'(i);
            w.last     = (i + 1 == n);
            expected_ranks.push_back(w);
        end
    endtask

    task automatic write_reg(input lpr_pkg::t_reg_idx idx,
                             input logic [lpr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            lpr_pkg::REG_MODULUS:    cfg_modulus    = data[lpr_pkg::M_W-1:0];
            lpr_pkg::REG_MULTIPLIER: cfg_multiplier = data[lpr_pkg::A_W-1:0];
            lpr_pkg::REG_INCREMENT:  cfg_increment  = data[lpr_pkg::C_W-1:0];
            lpr_pkg::REG_COUNT:      cfg_count      = data[lpr_pkg::N_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A seed with a zero count leaves nothing to wait for, so the block gets
    // its full latency before the registers change.
    task automatic settle();
        if (seeds_in_flight) begin
            i_seed_valid <= 1'b0;
            while (expected_ranks.size() != 0) @(posedge i_clk);
            repeat (drain_cycles()) @(posedge i_clk);
            seeds_in_flight = 1'b0;
        end
    endtask

    task automatic send_seed(input logic [lpr_pkg::Z_W-1:0] seed);
        while ($urandom_range(99) < snd_idle) begin
            i_seed_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_seed_valid <= 1'b1;
        i_seed       <= seed;
        do @(posedge i_clk); while (!o_seed_ready);
        seeds_in_flight = 1'b1;
    endtask

    function automatic void add_cfg(input lpr_pkg::t_reg_idx idx,
                                    input logic [lpr_pkg::CFG_DATA_W-1:0] data);
        t_plan_row row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.idx      = idx;
        row.data     = data;
        plan.push_back(row);
    endfunction

    function automatic void add_seed(input logic [lpr_pkg::Z_W-1:0] seed, input int in_order);
        t_plan_row row;
        row          = '0;
        row.kind     = ROW_SEED;
        row.seed     = seed;
        row.in_order = in_order;
        plan.push_back(row);
    endfunction

    // A negative in_order means the row is checked against the predictor.
    function automatic void build_plan();
        add_seed(35'd0, 60);
        add_seed(35'd1, -1);
        add_seed(35'h7_FFFF_FFFF, -1);
        add_cfg(lpr_pkg::REG_COUNT, 33'd5);
        add_cfg(lpr_pkg::REG_MODULUS, 33'd1);
        add_seed(35'h5_5555_5555, 5);
        add_cfg(lpr_pkg::REG_MODULUS, 33'd0);
        add_cfg(lpr_pkg::REG_MULTIPLIER, 33'hFF_FFFF);
        add_cfg(lpr_pkg::REG_INCREMENT, 33'hFFFF_FFFF);
        add_seed(35'h7_FFFF_FFFF, -1);
        add_seed(35'h2_AAAA_AAAA, -1);
        add_cfg(lpr_pkg::REG_COUNT, 33'd0);
        add_seed(35'd123, 0);
        add_cfg(lpr_pkg::REG_COUNT, 33'd1);
        add_seed(35'h1_2345_6789, 1);
        add_cfg(lpr_pkg::REG_MULTIPLIER, 33'd0);
        add_cfg(lpr_pkg::REG_COUNT, 33'd7);
        add_seed(35'd99, 7);
        add_cfg(lpr_pkg::REG_MODULUS, 33'd2);
        add_cfg(lpr_pkg::REG_MULTIPLIER, 33'd1);
        add_cfg(lpr_pkg::REG_INCREMENT, 33'd1);
        add_seed(35'd0, -1);
        add_cfg(lpr_pkg::REG_MODULUS, 33'h1_FFFF_FFFF);
        add_cfg(lpr_pkg::REG_MULTIPLIER, 33'd1664525);
        add_cfg(lpr_pkg::REG_INCREMENT, 33'd1013904223);
        add_cfg(lpr_pkg::REG_COUNT, 33'd127);
        add_seed(35'h4_0000_0001, -1);
        add_cfg(lpr_pkg::REG_MODULUS, 33'h1_0000_0000);
        add_cfg(lpr_pkg::REG_COUNT, 33'd64);
        add_seed(35'h3_0F0F_0F0F, -1);
    endfunction

    initial begin
        i_rank_ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_rank_ready <= 1'b0;
            end else begin
                i_rank_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    initial begin
        t_rank_word w;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rank_valid && i_rank_ready) begin
                if (expected_ranks.size() == 0) begin
                    report_mismatch($sformatf("unexpected word rank=%0d position=%0d last=%0b",
                                              o_rank, o_position, o_last));
                end else begin
                    w = expected_ranks.pop_front();
                    if (o_rank !== w.rank) begin
                        report_mismatch($sformatf("rank %0d, expected %0d at position %0d",
                                                  o_rank, w.rank, w.position));
                    end
                    if (o_position !== w.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  o_position, w.position));
                    end
                    if (o_last !== w.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b at position %0d",
                                                  o_last, w.last, w.position));
                    end
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int n_items;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= lpr_pkg::REG_MODULUS;
        i_cfg_data   <= '0;
        i_seed_valid <= 1'b0;
        i_seed       <= '0;
        mismatches      = 0;
        hold_req        = 1'b0;
        seeds_in_flight = 1'b0;
        snd_idle        = 24;
        rcv_idle        = 78;
        cfg_modulus     = lpr_pkg::MODULUS_RST;
        cfg_multiplier  = lpr_pkg::MULTIPLIER_RST;
        cfg_increment   = lpr_pkg::INCREMENT_RST;
        cfg_count       = lpr_pkg::COUNT_RST;
        build_plan();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                settle();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_seed(plan[k].seed);
                if (plan[k].in_order < 0) begin
                    predict_ranks(plan[k].seed);
                end else begin
                    expect_in_order(plan[k].in_order);
                end
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p < 4) begin
                snd_idle = 24;
                rcv_idle = 78;
            end else if (p < 8) begin
                snd_idle = 78;
                rcv_idle = 24;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            case (p % 5)
                0: write_reg(lpr_pkg::REG_MODULUS,
                             {1'($urandom_range(1, 0)), 32'($urandom())});
                1: write_reg(lpr_pkg::REG_MODULUS, 33'h1_0000_0000);
                2: write_reg(lpr_pkg::REG_MODULUS, 33'd0);
                3: write_reg(lpr_pkg::REG_MODULUS, 33'($urandom_range(200, 2)));
                default: write_reg(lpr_pkg::REG_MODULUS, 33'd2147483647);
            endcase
            case (p % 3)
                0: write_reg(lpr_pkg::REG_MULTIPLIER, 33'($urandom_range(24'hFF_FFFF, 0)));
                1: write_reg(lpr_pkg::REG_MULTIPLIER, 33'd1664525);
                default: write_reg(lpr_pkg::REG_MULTIPLIER, 33'($urandom_range(15, 1)));
            endcase
            if (p % 4 == 3) begin
                write_reg(lpr_pkg::REG_INCREMENT, 33'd0);
            end else if (p % 2 == 1) begin
                write_reg(lpr_pkg::REG_INCREMENT, 33'd1013904223);
            end else begin
                write_reg(lpr_pkg::REG_INCREMENT, 33'($urandom()));
            end
            n_items = 16;
            if (p == 5) begin
                write_reg(lpr_pkg::REG_COUNT, 33'd64);
                n_items = 4;
            end else if (p == 7) begin
                write_reg(lpr_pkg::REG_COUNT, 33'($urandom_range(127, 65)));
                n_items = 4;
            end else if (p == 2) begin
                write_reg(lpr_pkg::REG_COUNT, 33'($urandom_range(4, 1)));
            end else begin
                write_reg(lpr_pkg::REG_COUNT, 33'($urandom_range(16, 2)));
            end
            for (int k = 0; k < n_items; k++) begin
                logic [lpr_pkg::Z_W-1:0] seed;
                if ($urandom_range(7) == 0) begin
                    seed = lpr_pkg::Z_W'($urandom_range(3, 0));
                end else begin
                    seed = {3'($urandom_range(7, 0)), 32'($urandom())};
                end
                send_seed(seed);
                predict_ranks(seed);
                // Hold the result side off for a long stretch so the core
                // fills up and has to refuse the next seeds.
                if (p == PHASES - 1 && k == 0) begin
                    hold_req = 1'b1;
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
